[rtl/tdm_pkg.sv]
package tdm_pkg;

	localparam int FIELD_W     = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_TRANS = 2'd0,
		KIND_ACC   = 2'd1,
		KIND_BYTE  = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	// One classified word as it travels from the front end to the back end.
	typedef struct packed {
		kind_t              kind;
		logic [FIELD_W-1:0] state_index;
		logic [FIELD_W-1:0] symbol;
		logic [FIELD_W-1:0] next_state;
		logic               next_present;
		logic               accepting;
		logic               last;
		logic               state_ok;
		logic               symbol_ok;
	} op_t;

endpackage

[rtl/tdm_front.sv]
module tdm_front #(
	parameter int STATE_COUNT   = 256,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         q_full,
	output logic         q_push,
	output tdm_pkg::op_t q_op
);

	logic [tdm_pkg::FIELD_W-1:0] sidx;
	logic [tdm_pkg::FIELD_W-1:0] sym;

	assign sidx = s_tdata[7:0];
	assign sym  = s_tdata[15:8];

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_op.kind         = tdm_pkg::kind_t'(s_tuser);
		q_op.state_index  = sidx;
		q_op.symbol       = sym;
		q_op.next_state   = s_tdata[23:16];
		q_op.next_present = s_tdata[24];
		q_op.accepting    = s_tdata[25];
		q_op.last         = s_tlast;
		// Range checks are settled here so the back end only sees flags.
		q_op.state_ok     = {24'b0, sidx} < 32'(STATE_COUNT);
		q_op.symbol_ok    = {24'b0, sym} < 32'(ALPHABET_SIZE);
	end

endmodule

[rtl/tdm_queue.sv]
module tdm_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  tdm_pkg::op_t push_op,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output tdm_pkg::op_t pop_op
);

	tdm_pkg::op_t                  mem_q [tdm_pkg::QUEUE_DEPTH];
	logic [tdm_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [tdm_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [tdm_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full      = count_q == tdm_pkg::QCNT_W'(tdm_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

[rtl/tdm_back.sv]
module tdm_back #(
	parameter int STATE_COUNT   = 256,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         op_valid,
	input  tdm_pkg::op_t op,
	output logic         op_pop,
	output logic         res_valid,
	input  logic         res_ready,
	output logic         accepted,
	output logic         missing_transition
);

	localparam int ROWS      = (STATE_COUNT < 256) ? STATE_COUNT : 256;
	localparam int STATE_W   = $clog2(ROWS);
	localparam int SYM_W     = $clog2(ALPHABET_SIZE);
	localparam int ADDR_W    = STATE_W + SYM_W;
	localparam int TBL_DEPTH = ROWS << SYM_W;

	// Table entry: present bit on top, target state below.
	logic [tdm_pkg::FIELD_W:0] tbl_mem [TBL_DEPTH];
	logic                      acc_mem [ROWS];

	logic                 en;
	logic                 is_byte;
	logic [STATE_W-1:0]   in_state;
	logic                 in_dead;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;

	logic [STATE_W-1:0]   cur_q;
	logic                 dead_q;

	logic                 v_s2;
	tdm_pkg::kind_t       kind_s2;
	logic                 last_s2;
	logic [STATE_W-1:0]   state_s2;
	logic                 dead_s2;
	logic                 chk_s2;
	logic [tdm_pkg::FIELD_W:0] tbl_s2;

	logic                 tgt_ok;
	logic                 res_dead;
	logic [STATE_W-1:0]   res_state;
	logic                 word_end;
	logic [STATE_W-1:0]   after_state;
	logic                 after_dead;
	logic                 acc_rd;
	logic [STATE_W-1:0]   acc_addr;

	logic                 v_s3;
	logic                 miss_s3;
	logic                 use_acc_s3;
	logic                 acc_s3;

	// The whole back pipeline advances together; the queue absorbs input meanwhile.
	assign en      = !v_s3 || res_ready;
	assign op_pop  = en && op_valid;
	assign is_byte = op.kind == tdm_pkg::KIND_BYTE;

	// Resolve the byte in stage two from the registered table read.
	assign tgt_ok    = {24'b0, tbl_s2[tdm_pkg::FIELD_W-1:0]} < 32'(ROWS);
	assign res_dead  = dead_s2 || (chk_s2 && (!tbl_s2[tdm_pkg::FIELD_W] || !tgt_ok));
	assign res_state = chk_s2 ? tbl_s2[STATE_W-1:0] : state_s2;
	assign word_end  = (kind_s2 == tdm_pkg::KIND_EMPTY) ||
		(kind_s2 == tdm_pkg::KIND_BYTE && last_s2);

	always_comb begin
		if (word_end) begin
			after_state = '0;
			after_dead  = 1'b0;
		end else begin
			after_state = res_state;
			after_dead  = res_dead;
		end
	end

	// The next state feeds the next lookup address directly.
	always_comb begin
		if (v_s2) begin
			in_state = after_state;
			in_dead  = after_dead;
		end else begin
			in_state = cur_q;
			in_dead  = dead_q;
		end
	end

	assign rd_addr  = {in_state, op.symbol[SYM_W-1:0]};
	assign wr_addr  = {op.state_index[STATE_W-1:0], op.symbol[SYM_W-1:0]};
	assign acc_rd   = v_s2 && word_end;
	assign acc_addr = (kind_s2 == tdm_pkg::KIND_EMPTY) ? '0 : res_state;

	always_ff @(posedge clk) begin
		if (op_pop) begin
			if (op.kind == tdm_pkg::KIND_TRANS && op.state_ok && op.symbol_ok) begin
				tbl_mem[wr_addr] <= {op.next_present, op.next_state};
			end
			if (is_byte) begin
				tbl_s2 <= tbl_mem[rd_addr];
			end
		end
	end

	// An older word's read sees the old bit when a younger write lands on the same edge.
	always_ff @(posedge clk) begin
		if (op_pop && op.kind == tdm_pkg::KIND_ACC && op.state_ok) begin
			acc_mem[op.state_index[STATE_W-1:0]] <= op.accepting;
		end
		if (en && acc_rd) begin
			acc_s3 <= acc_mem[acc_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			cur_q  <= '0;
			dead_q <= 1'b0;
		end else if (en) begin
			v_s2 <= op_pop;
			v_s3 <= acc_rd;
			if (v_s2) begin
				cur_q  <= after_state;
				dead_q <= after_dead;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2    <= op.kind;
			last_s2    <= op.last;
			state_s2   <= in_state;
			dead_s2    <= in_dead || (is_byte && !op.symbol_ok);
			chk_s2     <= is_byte && !in_dead && op.symbol_ok;
			miss_s3    <= (kind_s2 == tdm_pkg::KIND_BYTE) && res_dead;
			use_acc_s3 <= !((kind_s2 == tdm_pkg::KIND_BYTE) && res_dead);
		end
	end

	assign res_valid          = v_s3;
	assign accepted           = use_acc_s3 && acc_s3;
	assign missing_transition = miss_s3;

endmodule

[rtl/table_driven_dfa_matcher.sv]
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid / s_tready  s_tdata, s_tuser (kind), s_tlast (last)
// m_       out  m_tvalid / m_tready  m_tdata (accepted, missing_transition)
//
// Sustained rate is one word per cycle while the output is not stalled, including
// consecutive bytes of a word: the registered table read drives the next lookup
// address combinationally. A result is offered from the stage-three registers.
// Reset clears the queue, the pipeline valids and the word state; the tables
// hold nothing until written and are not swept.
// Output backpressure freezes the back pipeline; the four-entry queue keeps
// taking input words until it fills.
module table_driven_dfa_matcher #(
	parameter int STATE_COUNT   = 256,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] state_index, [15:8] symbol, [23:16] next_state,
	// [24] next_present, [25] accepting, [31:26] zero
	input  logic [31:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [1] missing_transition, [7:2] zero
	output logic [7:0]  m_tdata
);

	tdm_pkg::op_t front_op;
	tdm_pkg::op_t back_op;
	logic         q_push;
	logic         q_full;
	logic         q_pop;
	logic         q_not_empty;
	logic         res_accepted;
	logic         res_missing;

	tdm_front #(
		.STATE_COUNT  (STATE_COUNT),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_op    (front_op)
	);

	tdm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_op  (front_op),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_op   (back_op)
	);

	tdm_back #(
		.STATE_COUNT  (STATE_COUNT),
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.op_valid          (q_not_empty),
		.op                (back_op),
		.op_pop            (q_pop),
		.res_valid         (m_tvalid),
		.res_ready         (m_tready),
		.accepted          (res_accepted),
		.missing_transition(res_missing)
	);

	assign m_tdata = {6'b0, res_missing, res_accepted};

	// A word rejected by a missing transition is never reported as accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("result both accepted and missing a transition");

	// While a result waits, nothing leaves the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !q_pop)
		else $error("queue popped while output stalled");

	// The queue only fills as a result of taking a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("input ready dropped without an accepted word");

endmodule

[test/dfa_result_checker.sv]
`timescale 1ns / 100ps

module dfa_result_checker #(
	parameter int STATE_COUNT   = 256,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// [7:0] state_index, [15:8] symbol, [23:16] next_state,
	// [24] next_present, [25] accepting, [31:26] zero
	input  logic [31:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [1] missing_transition, [7:2] zero
	input  logic [7:0]  m_tdata,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic accepted;
		logic missing_transition;
	} verdict_t;

	// Each entry holds the present bit above the target state.
	logic [8:0] trans_mem [0:STATE_COUNT*ALPHABET_SIZE-1];
	logic       accept_mem [0:STATE_COUNT-1];
	logic [7:0] walk_state;
	logic       walk_dead;
	verdict_t   verdict_q [$];

	function automatic logic accept_of(input int st);
		if (st >= STATE_COUNT)
			return 1'b0;
		return accept_mem[st];
	endfunction

	task automatic absorb(input tdm_pkg::kind_t kind, input logic [31:0] data,
			input logic last);
		logic [7:0] sidx;
		logic [7:0] sym;
		logic [8:0] entry;
		verdict_t   v;
		sidx = data[7:0];
		sym  = data[15:8];
		case (kind)
			tdm_pkg::KIND_TRANS: begin
				if (sidx < STATE_COUNT && sym < ALPHABET_SIZE)
					trans_mem[int'(sidx) * ALPHABET_SIZE + int'(sym)] = {data[24], data[23:16]};
			end
			tdm_pkg::KIND_ACC: begin
				if (sidx < STATE_COUNT)
					accept_mem[sidx] = data[25];
			end
			tdm_pkg::KIND_EMPTY: begin
				// Any string in progress is dropped without a result of its own.
				walk_state = 8'd0;
				walk_dead  = 1'b0;
				v.accepted = accept_of(0);
				v.missing_transition = 1'b0;
				verdict_q.push_back(v);
			end
			default: begin
				// Once a string has died, its remaining bytes touch nothing.
				if (!walk_dead) begin
					if (walk_state >= STATE_COUNT || sym >= ALPHABET_SIZE) begin
						walk_dead = 1'b1;
					end else begin
						entry = trans_mem[int'(walk_state) * ALPHABET_SIZE + int'(sym)];
						if (!entry[8] || entry[7:0] >= STATE_COUNT)
							walk_dead = 1'b1;
						else
							walk_state = entry[7:0];
					end
				end
				if (last) begin
					v.accepted = walk_dead ? 1'b0 : accept_of(int'(walk_state));
					v.missing_transition = walk_dead;
					verdict_q.push_back(v);
					walk_state = 8'd0;
					walk_dead  = 1'b0;
				end
			end
		endcase
	endtask

	always @(posedge clk) begin : watch
		verdict_t v;
		if (!arst_n) begin
			walk_state = 8'd0;
			walk_dead  = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: result %h with nothing expected", m_tdata);
				end else begin
					v = verdict_q.pop_front();
					if (m_tdata[0] !== v.accepted || m_tdata[1] !== v.missing_transition ||
							m_tdata[7:2] !== 6'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected accepted=%b missing_transition=%b, ",
								"got accepted=%b missing_transition=%b pad=%h"},
								v.accepted, v.missing_transition, m_tdata[0], m_tdata[1],
								m_tdata[7:2]);
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb(tdm_pkg::kind_t'(s_tuser), s_tdata, s_tlast);
		end
		pending = verdict_q.size();
	end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_TARGET  = 2000;

	typedef struct packed {
		tdm_pkg::kind_t kind;
		logic [7:0]     state_index;
		logic [7:0]     symbol;
		logic [7:0]     next_state;
		logic           next_present;
		logic           accepting;
		logic           last;
	} dfa_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	int          mismatches;
	int          pending;
	int          cycles = 0;
	int          results_seen = 0;
	int          items_sent;
	bit          send_calm;
	bit          take_calm = 1'b0;

	// What the stimulus has written so far, so that no string reads an unwritten entry.
	bit          trans_known [0:65535];
	logic [8:0]  trans_shadow [0:65535];
	bit          accept_known [0:255];
	logic [7:0]  path_state;
	bit          path_dead;

	// Strings mostly walk a small set of states over a small set of symbols.
	logic [7:0]  state_pool [0:7];
	logic [7:0]  symbol_pool [0:5];
	int          state_pool_n;
	int          symbol_pool_n;

	table_driven_dfa_matcher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	dfa_result_checker verdict_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL table_driven_dfa_matcher");
			$finish;
		end
	end

	function automatic dfa_item_t mk(input tdm_pkg::kind_t kind, input logic [7:0] sidx,
			input logic [7:0] sym, input logic [7:0] nxt, input logic pres,
			input logic acc, input logic last);
		dfa_item_t it;
		it.kind = kind;
		it.state_index = sidx;
		it.symbol = sym;
		it.next_state = nxt;
		it.next_present = pres;
		it.accepting = acc;
		it.last = last;
		return it;
	endfunction

	function automatic dfa_item_t noise_item(input tdm_pkg::kind_t kind);
		return mk(kind, 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom));
	endfunction

	function automatic logic [7:0] pick_state();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return state_pool[$urandom_range(0, state_pool_n - 1)];
	endfunction

	function automatic logic [7:0] pick_symbol();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return symbol_pool[$urandom_range(0, symbol_pool_n - 1)];
	endfunction

	task automatic send_item(input dfa_item_t it);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.kind;
		s_tlast  <= it.last;
		s_tdata  <= {6'd0, it.accepting, it.next_present, it.next_state, it.symbol,
			it.state_index};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		case (it.kind)
			tdm_pkg::KIND_TRANS: begin
				trans_known[{it.state_index, it.symbol}] = 1'b1;
				trans_shadow[{it.state_index, it.symbol}] = {it.next_present, it.next_state};
			end
			tdm_pkg::KIND_ACC: begin
				accept_known[it.state_index] = 1'b1;
			end
			tdm_pkg::KIND_EMPTY: begin
				path_state = 8'd0;
				path_dead  = 1'b0;
			end
			default: begin
				if (!path_dead) begin
					if (trans_shadow[{path_state, it.symbol}][8])
						path_state = trans_shadow[{path_state, it.symbol}][7:0];
					else
						path_dead = 1'b1;
				end
				if (it.last) begin
					path_state = 8'd0;
					path_dead  = 1'b0;
				end
			end
		endcase
	endtask

	task automatic write_trans(input logic [7:0] sidx, input logic [7:0] sym);
		dfa_item_t it;
		it = noise_item(tdm_pkg::KIND_TRANS);
		it.state_index = sidx;
		it.symbol = sym;
		it.next_present = ($urandom_range(0, 9) != 0);
		it.next_state = pick_state();
		send_item(it);
	endtask

	task automatic write_accept(input logic [7:0] sidx);
		dfa_item_t it;
		it = noise_item(tdm_pkg::KIND_ACC);
		it.state_index = sidx;
		send_item(it);
	endtask

	task automatic send_empty();
		if (!accept_known[0])
			write_accept(8'd0);
		send_item(noise_item(tdm_pkg::KIND_EMPTY));
	endtask

	// Writes whatever the next byte will read before sending it.
	task automatic feed_byte(input logic [7:0] sym, input logic last);
		dfa_item_t  it;
		logic [8:0] entry;
		if (!path_dead && !trans_known[{path_state, sym}])
			write_trans(path_state, sym);
		if (last && !path_dead) begin
			entry = trans_shadow[{path_state, sym}];
			if (entry[8] && !accept_known[entry[7:0]])
				write_accept(entry[7:0]);
		end
		it = noise_item(tdm_pkg::KIND_BYTE);
		it.symbol = sym;
		it.last = last;
		send_item(it);
	endtask

	task automatic run_string();
		int len;
		int i;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
		for (i = 0; i < len; i++) begin
			case ($urandom_range(0, 19))
				0: write_trans(pick_state(), pick_symbol());
				1: write_accept(pick_state());
				2: begin
					// An empty string abandons the one in progress.
					if (i > 0) begin
						send_empty();
						return;
					end
				end
				default: ;
			endcase
			feed_byte(pick_symbol(), i == len - 1);
		end
	endtask

	// Result side: short random stalls, calm stretches, and two long hold-offs.
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen == 150 || results_seen == 1000) begin
				m_tready <= 1'b0;
				repeat (120) @(posedge clk);
			end else begin
				stall = take_calm ? 0 : $urandom_range(0, 5);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			if (results_seen % 128 == 0)
				take_calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int i;
		int next_shuffle;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 32'd0;
		s_tuser  <= tdm_pkg::KIND_TRANS;
		s_tlast  <= 1'b0;
		path_state = 8'd0;
		path_dead  = 1'b0;
		send_calm  = 1'b0;
		items_sent = 0;
		next_shuffle = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty string on both values of the accepting bit of state 0.
		send_item(mk(tdm_pkg::KIND_ACC,   8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		send_item(mk(tdm_pkg::KIND_EMPTY, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 1'b1));
		send_item(mk(tdm_pkg::KIND_ACC,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		// One-byte string into the highest state.
		send_item(mk(tdm_pkg::KIND_TRANS, 8'h00, 8'h61, 8'hff, 1'b1, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_ACC,   8'hff, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h61, 8'h00, 1'b0, 1'b0, 1'b1));
		// Byte zero is an ordinary symbol.
		send_item(mk(tdm_pkg::KIND_TRANS, 8'hff, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'hff, 8'h61, 8'hff, 1'b1, 1'b1, 1'b0));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1));
		// Absent transition, then dead bytes up to the end of the string.
		send_item(mk(tdm_pkg::KIND_TRANS, 8'h00, 8'hff, 8'hff, 1'b0, 1'b1, 1'b1));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 1'b1));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'hff, 8'h00, 1'b0, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h5a, 8'h00, 1'b0, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h61, 8'h00, 1'b0, 1'b0, 1'b1));
		// Writes in the middle of a string take effect at once.
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h61, 8'h00, 1'b0, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_ACC,   8'hff, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_TRANS, 8'hff, 8'h61, 8'hff, 1'b1, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h61, 8'h00, 1'b0, 1'b0, 1'b1));
		// Empty string in the middle of another one.
		send_item(mk(tdm_pkg::KIND_BYTE,  8'h00, 8'h61, 8'h00, 1'b0, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
		send_item(mk(tdm_pkg::KIND_ACC,   8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
		send_item(mk(tdm_pkg::KIND_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= next_shuffle) begin
				state_pool_n = $urandom_range(2, 8);
				symbol_pool_n = $urandom_range(2, 6);
				state_pool[0] = 8'd0;
				for (i = 1; i < state_pool_n; i++)
					state_pool[i] = 8'($urandom_range(0, 255));
				for (i = 0; i < symbol_pool_n; i++)
					symbol_pool[i] = 8'($urandom_range(0, 255));
				send_calm = ($urandom_range(0, 3) == 0);
				next_shuffle = items_sent + 250;
			end
			case ($urandom_range(0, 19))
				0, 1: send_empty();
				2, 3: write_trans(pick_state(), pick_symbol());
				4: write_accept(pick_state());
				5: send_item(noise_item($urandom_range(0, 1) ? tdm_pkg::KIND_ACC :
					tdm_pkg::KIND_TRANS));
				default: run_string();
			endcase
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("PASS table_driven_dfa_matcher");
		else
			$display("FAIL table_driven_dfa_matcher");
		$finish;
	end

endmodule
